// File: hdl/vertex_transform_project_clip_core_assert.svh
// Assertion macros for the vertex transform and projection checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef VERTEX_TRANSFORM_PROJECT_CLIP_CORE_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_CLIP_CORE_ASSERT_SVH

// Check a same-cycle implication.
`define VTPC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtpc assertion failed");

// Check an implication in the next cycle.
`define VTPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtpc assertion failed");

`endif

// File: hdl/vtpc_pkg.sv
// Shared types and constants for the vertex transform and projection core.
// No dependencies.
package vtpc_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int MATRIX_SHIFT_DEF = 14;

    localparam int WORD_W      = 32;
    localparam int FLAGS_W     = 11;
    localparam int AXES        = 3;
    localparam int ROW_WORDS   = 4;
    localparam int ORIGIN_BASE = 12;
    localparam int COEF_COUNT  = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int DIV_BITS    = 63;

    localparam logic signed [31:0] NEAR_DEPTH = 32'sd32;
    localparam logic signed [31:0] FAR_DEPTH  = 32'sd11232;

    localparam logic [FLAGS_W-1:0] FLAG_SPLIT1 = 11'h001;
    localparam logic [FLAGS_W-1:0] FLAG_SPLIT2 = 11'h002;
    localparam logic [FLAGS_W-1:0] FLAG_LEFT   = 11'h008;
    localparam logic [FLAGS_W-1:0] FLAG_RIGHT  = 11'h010;
    localparam logic [FLAGS_W-1:0] FLAG_TOP    = 11'h020;
    localparam logic [FLAGS_W-1:0] FLAG_BOTTOM = 11'h040;
    localparam logic [FLAGS_W-1:0] FLAG_FADE   = 11'h080;
    localparam logic [FLAGS_W-1:0] FLAG_NEAR   = 11'h100;
    localparam logic [FLAGS_W-1:0] FLAG_PROJ   = 11'h400;

    localparam logic [1:0] MODE_PARALLEL = 2'd0;
    localparam logic [1:0] MODE_STANDARD = 2'd1;
    localparam logic [1:0] MODE_CIRCULAR = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLITS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] lens;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] width;
        logic [15:0] height;
        logic [30:0] fade_limit;
        logic [15:0] split1;
        logic [15:0] split2;
        logic [30:0] zoom;
        logic [31:0] depth_offset;
    } cfg_t;

    // Transformed vertex passed from front to back
    typedef struct packed {
        logic [31:0]        tx;
        logic [31:0]        ty;
        logic [31:0]        tz;
        logic [FLAGS_W-1:0] flags;
    } point_t;

endpackage

// File: hdl/vtpc_fifo.sv
// Small register queue between the transform front and the projection back.
// Depends on vtpc_pkg for point_t.
module vtpc_fifo
    import vtpc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  point_t                       push_data,
    input  logic                         pop,
    output point_t                       pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    point_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// File: hdl/vtpc_front.sv
// Front end: accepts requests, loads the coefficient store and runs the
// three-stage rotate/translate pipeline. Depends on vtpc_pkg.
module vtpc_front
    import vtpc_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int MATRIX_SHIFT = MATRIX_SHIFT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [3:0]                        coef_index,
    input  logic signed [31:0]                coef_value,
    input  logic signed [31:0]                vertex_x,
    input  logic signed [31:0]                vertex_y,
    input  logic signed [31:0]                vertex_z,
    input  logic [FLAGS_W-1:0]                prior_flags,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count,
    output logic                              push,
    output point_t                            push_data
);

    localparam int CNT_W = $clog2(FIFO_DEPTH+1);
    localparam int OCC_W = CNT_W + 1;

    logic accept;

    logic [31:0] coef_reg [COEF_COUNT];

    logic               f0_valid_reg;
    logic signed [31:0] f0_x_reg, f0_y_reg, f0_z_reg;
    logic [FLAGS_W-1:0] f0_flags_reg;

    logic               f1_valid_reg;
    logic signed [63:0] f1_pc_reg [AXES];
    logic signed [63:0] f1_pb_reg [AXES];
    logic signed [63:0] f1_pa_reg [AXES];
    logic signed [63:0] f1_pab_reg [AXES];
    logic signed [31:0] f1_d_reg [AXES];
    logic signed [31:0] f1_org_reg [AXES];
    logic [FLAGS_W-1:0] f1_flags_reg;

    logic               f2_valid_reg;
    logic signed [63:0] f2_sa_reg [AXES];
    logic signed [63:0] f2_sb_reg [AXES];
    logic signed [31:0] f2_org_reg [AXES];
    logic [FLAGS_W-1:0] f2_flags_reg;

    logic signed [63:0] pc_next [AXES];
    logic signed [63:0] pb_next [AXES];
    logic signed [63:0] pa_next [AXES];
    logic signed [63:0] pab_next [AXES];
    logic signed [63:0] sa_next [AXES];
    logic signed [63:0] sb_next [AXES];
    logic [31:0]        t_axis [AXES];

    logic [1:0]       inflight;
    logic [OCC_W-1:0] occupancy;

    // Reserve a queue slot for every vertex still in the pipeline
    assign inflight  = {1'b0, f0_valid_reg} + {1'b0, f1_valid_reg} + {1'b0, f2_valid_reg};
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(inflight);
    assign in_ready  = (occupancy < OCC_W'(FIFO_DEPTH));
    assign accept    = in_valid && in_ready;

    // Load coefficient words; the unused top index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (accept && (req_type == REQ_WRITE) && (coef_index < 4'(COEF_COUNT)))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // Capture the vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f0_valid_reg <= accept && (req_type == REQ_VERTEX);
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f0_x_reg     <= vertex_x;
            f0_y_reg     <= vertex_y;
            f0_z_reg     <= vertex_z;
            f0_flags_reg <= prior_flags;
        end
    end

    // Form the row products: z*c + y*b + x*a + a*b - d equals the row sum
    always_comb
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            pc_next[ax]  = f0_z_reg * $signed(coef_reg[ax*ROW_WORDS+2]);
            pb_next[ax]  = f0_y_reg * $signed(coef_reg[ax*ROW_WORDS+1]);
            pa_next[ax]  = f0_x_reg * $signed(coef_reg[ax*ROW_WORDS]);
            pab_next[ax] = $signed(coef_reg[ax*ROW_WORDS]) *
                           $signed(coef_reg[ax*ROW_WORDS+1]);
        end
    end

    // Hold products together with the offset and origin seen by this vertex
    always_ff @(posedge clk)
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            f1_pc_reg[ax]  <= pc_next[ax];
            f1_pb_reg[ax]  <= pb_next[ax];
            f1_pa_reg[ax]  <= pa_next[ax];
            f1_pab_reg[ax] <= pab_next[ax];
            f1_d_reg[ax]   <= $signed(coef_reg[ax*ROW_WORDS+3]);
            f1_org_reg[ax] <= $signed(coef_reg[ORIGIN_BASE+ax]);
        end
        f1_flags_reg <= f0_flags_reg;
    end

    // Partial sums
    always_comb
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            sa_next[ax] = f1_pc_reg[ax] + f1_pb_reg[ax];
            sb_next[ax] = f1_pa_reg[ax] + f1_pab_reg[ax] - 64'(f1_d_reg[ax]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            f2_sa_reg[ax]  <= sa_next[ax];
            f2_sb_reg[ax]  <= sb_next[ax];
            f2_org_reg[ax] <= f1_org_reg[ax];
        end
        f2_flags_reg <= f1_flags_reg;
    end

    // Finish the row sum, shift, add origin and wrap to the coordinate width
    always_comb
    begin
        logic signed [63:0] acc;
        logic signed [63:0] total;
        for (int ax = 0; ax < AXES; ax++)
        begin
            acc        = f2_sa_reg[ax] + f2_sb_reg[ax];
            total      = (acc >>> MATRIX_SHIFT) + 64'(f2_org_reg[ax]);
            t_axis[ax] = WORD_W'($signed(total[COORD_BITS-1:0]));
        end
    end

    assign push            = f2_valid_reg;
    assign push_data.tx    = t_axis[0];
    assign push_data.ty    = t_axis[1];
    assign push_data.tz    = t_axis[2];
    assign push_data.flags = f2_flags_reg;

endmodule

// File: hdl/vtpc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vtpc_pkg for the default widths.
module vtpc_divider
    import vtpc_pkg::*;
#(
    parameter int N_BITS = DIV_BITS,
    parameter int D_BITS = WORD_W
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [N_BITS-1:0] dividend,
    input  logic [D_BITS-1:0] divisor,
    output logic [N_BITS-1:0] quotient
);

    logic [D_BITS-1:0] rem_reg [N_BITS];
    logic [D_BITS-1:0] dv_reg  [N_BITS];
    logic [N_BITS-1:0] w_reg   [N_BITS];

    for (genvar i = 0; i < N_BITS; i++)
    begin : g_stage
        logic [D_BITS-1:0] rem_in;
        logic [D_BITS-1:0] dv_in;
        logic [N_BITS-1:0] w_in;
        logic [D_BITS:0]   trial;
        logic              take;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign dv_in  = divisor;
            assign w_in   = dividend;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign dv_in  = dv_reg[i-1];
            assign w_in   = w_reg[i-1];
        end

        // Shift in the next dividend bit and try a subtract
        assign trial = {rem_in, w_in[N_BITS-1]};
        assign take  = (trial >= {1'b0, dv_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? D_BITS'(trial - {1'b0, dv_in}) : trial[D_BITS-1:0];
                dv_reg[i]  <= dv_in;
                w_reg[i]   <= {w_in[N_BITS-2:0], take};
            end
        end
    end

    assign quotient = w_reg[N_BITS-1];

endmodule

// File: hdl/vtpc_back.sv
// Back end: projects transformed points, sets clip flags and holds the
// output register. Depends on vtpc_pkg and vtpc_divider.
module vtpc_back
    import vtpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                fifo_empty,
    input  point_t              fifo_data,
    output logic                fifo_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  screen_x,
    output logic signed [31:0]  screen_y,
    output logic signed [31:0]  depth_out,
    output logic signed [31:0]  fade_distance,
    output logic [FLAGS_W-1:0]  clip_flags
);

    typedef struct packed {
        logic [31:0]        tx;
        logic [31:0]        ty;
        logic               sign_x;
        logic               sign_y;
        logic               use_div;
        logic               use_mul;
        logic [31:0]        alt_x;
        logic [31:0]        alt_y;
        logic [31:0]        depth;
        logic [31:0]        fade;
        logic [FLAGS_W-1:0] flags;
    } side_t;

    logic en;
    logic par, circ;

    logic   b0_valid_reg;
    point_t b0_pt_reg;

    logic               b1_valid_reg;
    point_t             b1_pt_reg;
    logic [63:0]        b1_px_reg, b1_py_reg;

    logic  dv_valid_reg [DIV_BITS];
    side_t dv_side_reg  [DIV_BITS];

    logic               b3_valid_reg;
    logic [31:0]        b3_ws_x_reg, b3_ws_y_reg;
    logic [31:0]        b3_mul_x_reg, b3_mul_y_reg;
    logic               b3_use_mul_reg;
    logic [31:0]        b3_depth_reg, b3_fade_reg;
    logic [FLAGS_W-1:0] b3_flags_reg;

    logic               out_valid_reg;
    logic [31:0]        sx_reg, sy_reg, depth_reg, fade_reg;
    logic [FLAGS_W-1:0] flags_reg;

    logic [31:0]        mul_op;
    logic signed [64:0] full_x, full_y;

    side_t                side_next;
    logic [DIV_BITS-1:0]  dividend_x, dividend_y;
    logic [31:0]          divisor;
    logic [DIV_BITS-1:0]  qx, qy;

    logic [63:0]        sq_x, sq_y;
    logic signed [64:0] mul_full_x, mul_full_y;

    logic [31:0]        sx_next, sy_next;
    logic [FLAGS_W-1:0] flags_next;

    assign par  = (cfg.mode == MODE_PARALLEL);
    assign circ = (cfg.mode == MODE_CIRCULAR);

    // Stall every stage together while a result waits at the output
    assign en       = !out_valid_reg || out_ready;
    assign fifo_pop = en && !fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_BITS; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            b0_valid_reg    <= !fifo_empty;
            b1_valid_reg    <= b0_valid_reg;
            dv_valid_reg[0] <= b1_valid_reg;
            for (int i = 1; i < DIV_BITS; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            b3_valid_reg  <= dv_valid_reg[DIV_BITS-1];
            out_valid_reg <= b3_valid_reg;
        end
    end

    // Take the queued point
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_pt_reg <= fifo_data;
        end
    end

    // Scale by zoom in parallel mode, by the lens otherwise
    assign mul_op = par ? {1'b0, cfg.zoom} : {cfg.lens, 16'b0};
    assign full_x = $signed(b0_pt_reg.tx) * $signed({1'b0, mul_op});
    assign full_y = $signed(b0_pt_reg.ty) * $signed({1'b0, mul_op});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_pt_reg <= b0_pt_reg;
            b1_px_reg <= full_x[63:0];
            b1_py_reg <= full_y[63:0];
        end
    end

    // Classify the point and prepare the divider operands
    always_comb
    begin
        logic signed [31:0] tz;
        logic               near;
        logic [63:0]        mag_x, mag_y;
        logic [31:0]        abs_tx, abs_ty;
        logic signed [31:0] shifted_sum;
        logic signed [31:0] half;
        logic [FLAGS_W-1:0] f;

        tz     = $signed(b1_pt_reg.tz);
        near   = (tz < NEAR_DEPTH);
        mag_x  = b1_px_reg[63] ? (64'd0 - b1_px_reg) : b1_px_reg;
        mag_y  = b1_py_reg[63] ? (64'd0 - b1_py_reg) : b1_py_reg;
        abs_tx = b1_pt_reg.tx[31] ? (32'd0 - b1_pt_reg.tx) : b1_pt_reg.tx;
        abs_ty = b1_pt_reg.ty[31] ? (32'd0 - b1_pt_reg.ty) : b1_pt_reg.ty;

        // Parallel depth: halve toward zero, then clamp
        shifted_sum = $signed(b1_pt_reg.tz + {cfg.depth_offset[23:0], 8'b0});
        half        = $signed(shifted_sum + 32'(shifted_sum[31])) >>> 1;

        f = b1_pt_reg.flags;
        if (!par)
        begin
            f = f | FLAG_PROJ;
            if (tz > $signed({1'b0, cfg.fade_limit}))
            begin
                f = f | FLAG_FADE;
            end
            if (near)
            begin
                f = f | FLAG_NEAR | FLAG_SPLIT1 | FLAG_SPLIT2;
            end
            else if (tz < $signed({16'b0, cfg.split1}))
            begin
                f = f | FLAG_SPLIT1;
                if (tz < $signed({16'b0, cfg.split2}))
                begin
                    f = f | FLAG_SPLIT2;
                end
            end
        end

        side_next.tx      = b1_pt_reg.tx;
        side_next.ty      = b1_pt_reg.ty;
        side_next.sign_x  = b1_px_reg[63];
        side_next.sign_y  = b1_py_reg[63];
        side_next.use_div = !par && !near && !circ;
        side_next.use_mul = !par && !near && circ;
        side_next.flags   = f;

        if (par)
        begin
            side_next.alt_x = b1_px_reg[47:16];
            side_next.alt_y = b1_py_reg[47:16];
            side_next.fade  = '0;
            if (half < NEAR_DEPTH)
            begin
                side_next.depth = '0;
            end
            else if (half >= FAR_DEPTH)
            begin
                side_next.depth = FAR_DEPTH;
            end
            else
            begin
                side_next.depth = half;
            end
        end
        else
        begin
            side_next.alt_x = circ ? {b1_pt_reg.tx[28:0], 3'b0} : b1_pt_reg.tx;
            side_next.alt_y = circ ? {b1_pt_reg.ty[28:0], 3'b0} : b1_pt_reg.ty;
            side_next.fade  = circ ? (abs_tx + abs_ty + b1_pt_reg.tz) : b1_pt_reg.tz;
            side_next.depth = b1_pt_reg.tz;
        end

        dividend_x = circ ? {15'b0, cfg.lens, 32'b0} >> 16 : mag_x[DIV_BITS-1:0];
        dividend_y = mag_y[DIV_BITS-1:0];
        divisor    = near ? 32'd1 : b1_pt_reg.tz;
    end

    vtpc_divider #(
        .N_BITS (DIV_BITS),
        .D_BITS (WORD_W)
    ) u_div_x (
        .clk      (clk),
        .en       (en),
        .dividend (dividend_x),
        .divisor  (divisor),
        .quotient (qx)
    );

    vtpc_divider #(
        .N_BITS (DIV_BITS),
        .D_BITS (WORD_W)
    ) u_div_y (
        .clk      (clk),
        .en       (en),
        .dividend (dividend_y),
        .divisor  (divisor),
        .quotient (qy)
    );

    // Carry the point details alongside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= side_next;
            for (int i = 1; i < DIV_BITS; i++)
            begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // Restore the quotient sign and scale for circular mode
    assign sq_x = dv_side_reg[DIV_BITS-1].sign_x ? (64'd0 - {1'b0, qx}) : {1'b0, qx};
    assign sq_y = dv_side_reg[DIV_BITS-1].sign_y ? (64'd0 - {1'b0, qy}) : {1'b0, qy};
    assign mul_full_x = $signed(dv_side_reg[DIV_BITS-1].tx) * $signed({1'b0, qx[31:0]});
    assign mul_full_y = $signed(dv_side_reg[DIV_BITS-1].ty) * $signed({1'b0, qx[31:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_ws_x_reg    <= dv_side_reg[DIV_BITS-1].use_div ? sq_x[47:16]
                                                              : dv_side_reg[DIV_BITS-1].alt_x;
            b3_ws_y_reg    <= dv_side_reg[DIV_BITS-1].use_div ? sq_y[47:16]
                                                              : dv_side_reg[DIV_BITS-1].alt_y;
            b3_mul_x_reg   <= mul_full_x[47:16];
            b3_mul_y_reg   <= mul_full_y[47:16];
            b3_use_mul_reg <= dv_side_reg[DIV_BITS-1].use_mul;
            b3_depth_reg   <= dv_side_reg[DIV_BITS-1].depth;
            b3_fade_reg    <= dv_side_reg[DIV_BITS-1].fade;
            b3_flags_reg   <= dv_side_reg[DIV_BITS-1].flags;
        end
    end

    // Offset from the view center and test the window edges
    always_comb
    begin
        logic [31:0] ws_x, ws_y;
        ws_x    = b3_use_mul_reg ? b3_mul_x_reg : b3_ws_x_reg;
        ws_y    = b3_use_mul_reg ? b3_mul_y_reg : b3_ws_y_reg;
        sx_next = {16'b0, cfg.center_x} + ws_x;
        sy_next = {16'b0, cfg.center_y} - ws_y;

        flags_next = b3_flags_reg;
        if (sx_next[31])
        begin
            flags_next = flags_next | FLAG_LEFT;
        end
        else if (sx_next >= {16'b0, cfg.width})
        begin
            flags_next = flags_next | FLAG_RIGHT;
        end
        if (sy_next[31])
        begin
            flags_next = flags_next | FLAG_TOP;
        end
        else if (sy_next >= {16'b0, cfg.height})
        begin
            flags_next = flags_next | FLAG_BOTTOM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            depth_reg <= b3_depth_reg;
            fade_reg  <= b3_fade_reg;
            flags_reg <= flags_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign screen_x      = $signed(sx_reg);
    assign screen_y      = $signed(sy_reg);
    assign depth_out     = $signed(depth_reg);
    assign fade_distance = $signed(fade_reg);
    assign clip_flags    = flags_reg;

endmodule

// File: hdl/vertex_transform_project_clip_core.sv
// Vertex transform, projection and clip-code core: one vertex per cycle while
// in_ready is high and no result is stalled at the output by out_ready.
// The rate is held back by the front credit check and by output back-pressure;
// the back divider pipeline retires one quotient bit per stage over 63 stages.
// Reset: configuration registers take their default values, the coefficient store
// clears at once and both pipelines and the queue empty; no clearing pass.
module vertex_transform_project_clip_core
    import vtpc_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int MATRIX_SHIFT = MATRIX_SHIFT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [3:0]            coef_index,
    input  logic signed [31:0]    coef_value,
    input  logic signed [31:0]    vertex_x,
    input  logic signed [31:0]    vertex_y,
    input  logic signed [31:0]    vertex_z,
    input  logic [FLAGS_W-1:0]    prior_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    screen_x,
    output logic signed [31:0]    screen_y,
    output logic signed [31:0]    depth_out,
    output logic signed [31:0]    fade_distance,
    output logic [FLAGS_W-1:0]    clip_flags,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    cfg_t cfg_reg;

    logic                            push;
    point_t                          push_data;
    logic                            pop;
    point_t                          pop_data;
    logic                            fifo_empty;
    logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_STANDARD;
            cfg_reg.lens         <= 16'd256;
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.width        <= '0;
            cfg_reg.height       <= '0;
            cfg_reg.fade_limit   <= '0;
            cfg_reg.split1       <= '0;
            cfg_reg.split2       <= '0;
            cfg_reg.zoom         <= 31'd65536;
            cfg_reg.depth_offset <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:         cfg_reg.mode <= cfg_data[1:0];
                CFG_LENS:         cfg_reg.lens <= cfg_data[15:0];
                CFG_CENTER:
                begin
                    cfg_reg.center_x <= cfg_data[15:0];
                    cfg_reg.center_y <= cfg_data[31:16];
                end
                CFG_WINDOW:
                begin
                    cfg_reg.width  <= cfg_data[15:0];
                    cfg_reg.height <= cfg_data[31:16];
                end
                CFG_FADE_LIMIT:   cfg_reg.fade_limit <= cfg_data[30:0];
                CFG_SPLITS:
                begin
                    cfg_reg.split1 <= cfg_data[15:0];
                    cfg_reg.split2 <= cfg_data[31:16];
                end
                CFG_ZOOM:         cfg_reg.zoom <= cfg_data[30:0];
                CFG_DEPTH_OFFSET: cfg_reg.depth_offset <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    vtpc_front #(
        .COORD_BITS   (COORD_BITS),
        .MATRIX_SHIFT (MATRIX_SHIFT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .vertex_z    (vertex_z),
        .prior_flags (prior_flags),
        .fifo_count  (fifo_count),
        .push        (push),
        .push_data   (push_data)
    );

    vtpc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty),
        .count     (fifo_count)
    );

    vtpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .fifo_empty    (fifo_empty),
        .fifo_data     (pop_data),
        .fifo_pop      (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .depth_out     (depth_out),
        .fade_distance (fade_distance),
        .clip_flags    (clip_flags)
    );

endmodule

// File: hdl/vtpc_checker.sv
// Port-level checker for the vertex transform and projection core, bound to
// the top level. Depends on vtpc_pkg and the assertion macro header.
`include "vertex_transform_project_clip_core_assert.svh"

module vtpc_checker
    import vtpc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic signed [31:0]    screen_x,
    input logic signed [31:0]    screen_y,
    input logic signed [31:0]    depth_out,
    input logic signed [31:0]    fade_distance,
    input logic [FLAGS_W-1:0]    clip_flags
);

    // Hold a stalled result
    `VTPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(screen_x) && $stable(clip_flags) && $stable(depth_out))

    // Negative screen coordinates always carry their edge flag
    `VTPC_ASSERT_IMPLY(a_left_edge, out_valid && screen_x[31], clip_flags[3])
    `VTPC_ASSERT_IMPLY(a_top_edge, out_valid && screen_y[31], clip_flags[5])

    // Unprojected results come from parallel mode: no fade, clamped depth
    `VTPC_ASSERT_IMPLY(a_parallel_depth, out_valid && !clip_flags[10], fade_distance == 32'sd0 && !depth_out[31] && depth_out <= 32'sd11232)

    // Nothing leaves the pipeline right after reset
    `VTPC_ASSERT_IMPLY(a_empty_after_reset, $rose(rst_n), !out_valid)

endmodule

bind vertex_transform_project_clip_core vtpc_checker u_vtpc_checker (.*);

// File: test/tb_top.sv
// Self-checking bench for vertex_transform_project_clip_core: a predictor of
// the transform, projection and clip codes checks every result in order.
// Depends on vtpc_pkg and the core RTL.
module tb_top;
    import vtpc_pkg::*;

    localparam int LATENCY   = 70;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic        req;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [10:0] pflags;
    } request_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] depth;
        logic [31:0] fade;
        logic [10:0] flags;
    } projection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic [3:0] coef_index = '0;
    logic signed [31:0] coef_value = '0;
    logic signed [31:0] vertex_x = '0;
    logic signed [31:0] vertex_y = '0;
    logic signed [31:0] vertex_z = '0;
    logic [FLAGS_W-1:0] prior_flags = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_out;
    logic signed [31:0] fade_distance;
    logic [FLAGS_W-1:0] clip_flags;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predictor copy of state and registers
    logic [31:0] coef_mem [COEF_COUNT];
    logic [1:0]  m_mode;
    logic [15:0] m_lens;
    logic [31:0] m_center;
    logic [31:0] m_window;
    logic [30:0] m_fade_lim;
    logic [31:0] m_splits;
    logic [30:0] m_zoom;
    logic [31:0] m_doff;

    request_t    pending_reqs[$];
    projection_t expected_proj[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          wdog = 0;

    vertex_transform_project_clip_core dut (.*);

    always #2 clk = ~clk;

    function automatic longint transform_row(longint px, longint py, longint pz, int axis);
        longint a, b, c, d, acc, sh;
        logic [31:0] w;
        a = longint'($signed(coef_mem[axis*4]));
        b = longint'($signed(coef_mem[axis*4+1]));
        c = longint'($signed(coef_mem[axis*4+2]));
        d = longint'($signed(coef_mem[axis*4+3]));
        acc = pz * c + (py + a) * (px + b) - d - px * py;
        sh = acc >>> 14;
        w = coef_mem[ORIGIN_BASE + axis] + sh[31:0];
        return longint'($signed(w));
    endfunction

    function automatic logic [10:0] edge_code(longint v, longint size,
                                              logic [10:0] lo, logic [10:0] hi);
        if (v < 0) return lo;
        if (v >= size) return hi;
        return '0;
    endfunction

    // Apply one request to the model; returns 1 when a projection results
    function automatic bit project_vertex(request_t r, output projection_t p);
        longint px, py, pz, tx, ty, tz, sx, sy, fd, wx, wy, cx, cy, lens, k, d;
        logic [31:0] w;
        logic [63:0] ax, ay;
        logic [10:0] fl;
        bit circ;
        p = '0;
        if (r.req == REQ_WRITE) begin
            if (r.idx < COEF_COUNT) coef_mem[r.idx] = r.value;
            return 1'b0;
        end
        fl = r.pflags;
        fd = 0;
        cx = longint'(m_center[15:0]);
        cy = longint'(m_center[31:16]);
        px = longint'($signed(r.vx));
        py = longint'($signed(r.vy));
        pz = longint'($signed(r.vz));
        tx = transform_row(px, py, pz, 0);
        ty = transform_row(px, py, pz, 1);
        tz = transform_row(px, py, pz, 2);
        if (m_mode == MODE_PARALLEL) begin
            w = tz[31:0] + (m_doff << 8);
            d = longint'($signed(w)) / 2;
            k = (tx * longint'(m_zoom)) >>> 16;
            w = cx[31:0] + k[31:0];
            sx = longint'($signed(w));
            k = (ty * longint'(m_zoom)) >>> 16;
            w = cy[31:0] - k[31:0];
            sy = longint'($signed(w));
            if (d < NEAR_DEPTH) d = 0;
            else if (d >= FAR_DEPTH) d = FAR_DEPTH;
            tz = d;
        end else begin
            circ = (m_mode == MODE_CIRCULAR);
            lens = longint'(m_lens) * 65536;
            if (circ) begin
                ax = tx < 0 ? -tx : tx;
                ay = ty < 0 ? -ty : ty;
                w = ax[31:0] + ay[31:0] + tz[31:0];
                fd = longint'($signed(w));
            end else begin
                fd = tz;
            end
            if (tz > longint'(m_fade_lim)) fl |= FLAG_FADE;
            if (tz < NEAR_DEPTH) begin
                fl |= FLAG_NEAR | FLAG_SPLIT1 | FLAG_SPLIT2;
                wx = tx * (circ ? 524288 : 65536);
                wy = ty * (circ ? 524288 : 65536);
            end else begin
                if (circ) begin
                    k = lens / tz;
                    wx = tx * k;
                    wy = ty * k;
                end else begin
                    wx = tx * lens / tz;
                    wy = ty * lens / tz;
                end
                if (tz < longint'(m_splits[15:0])) begin
                    fl |= FLAG_SPLIT1;
                    if (tz < longint'(m_splits[31:16])) fl |= FLAG_SPLIT2;
                end
            end
            k = wx >>> 16;
            w = cx[31:0] + k[31:0];
            sx = longint'($signed(w));
            k = wy >>> 16;
            w = cy[31:0] - k[31:0];
            sy = longint'($signed(w));
            fl |= FLAG_PROJ;
        end
        fl |= edge_code(sx, longint'(m_window[15:0]), FLAG_LEFT, FLAG_RIGHT);
        fl |= edge_code(sy, longint'(m_window[31:16]), FLAG_TOP, FLAG_BOTTOM);
        p.sx = sx[31:0];
        p.sy = sy[31:0];
        p.depth = tz[31:0];
        p.fade = fd[31:0];
        p.flags = fl;
        return 1'b1;
    endfunction

    // Drive pending requests, idling at random, and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || in_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= r.req;
                    coef_index <= r.idx;
                    coef_value <= r.value;
                    vertex_x <= r.vx;
                    vertex_y <= r.vy;
                    vertex_z <= r.vz;
                    prior_flags <= r.pflags;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        projection_t p, got;
        request_t r;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                r = '{req_type, coef_index, coef_value, vertex_x, vertex_y, vertex_z,
                      prior_flags};
                if (project_vertex(r, p)) expected_proj.push_back(p);
            end
            if (out_valid && out_ready) begin
                got = '{screen_x, screen_y, depth_out, fade_distance, clip_flags};
                if (expected_proj.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    p = expected_proj.pop_front();
                    if (p !== got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp %h got %h", p, got);
                    end
                end
            end
            // Count cycles with no transfer
            if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
            else wdog <= wdog + 1;
        end
    end

    // Stop on a stalled run
    always @(posedge clk)
    begin
        if (wdog >= WDOG_MAX) begin
            $display("vertex_transform_project_clip_core: mismatch");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:         m_mode = data[1:0];
            CFG_LENS:         m_lens = data[15:0];
            CFG_CENTER:       m_center = data;
            CFG_WINDOW:       m_window = data;
            CFG_FADE_LIMIT:   m_fade_lim = data[30:0];
            CFG_SPLITS:       m_splits = data;
            CFG_ZOOM:         m_zoom = data[30:0];
            default:          m_doff = data;
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_reqs.size() > 0 || in_valid || expected_proj.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(64) - 32;
            3: return $urandom;
            default: return $urandom_range(4096) - 2048;
        endcase
    endfunction

    function automatic request_t coef_req(int idx, logic [31:0] v);
        request_t r;
        r = '0;
        r.req = REQ_WRITE;
        r.idx = 4'(idx);
        r.value = v;
        r.vx = $urandom;
        r.vy = $urandom;
        r.vz = $urandom;
        r.pflags = 11'($urandom);
        return r;
    endfunction

    function automatic request_t vertex_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        request_t r;
        r.req = REQ_VERTEX;
        r.idx = 4'($urandom);
        r.value = $urandom;
        r.vx = x;
        r.vy = y;
        r.vz = z;
        r.pflags = 11'($urandom);
        return r;
    endfunction

    // Queue a coefficient load: random words when wild, else small random terms and a unit z term
    task automatic queue_matrix(bit wild);
        int i;
        logic [31:0] v;
        for (i = 0; i < COEF_COUNT; i++) begin
            if (wild) v = rand_word();
            else if (i < 12 && (i % 4) == 2 && i / 4 == 2) v = 32'd16384;
            else if (i < 12) v = $urandom_range(8) - 4;
            else if (i == 14) v = $urandom_range(3000);
            else v = $urandom_range(400) - 200;
            pending_reqs.push_back(coef_req(i, v));
        end
    endtask

    task automatic queue_vertices(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                pending_reqs.push_back(vertex_req(rand_word(), rand_word(), rand_word()));
            else
                pending_reqs.push_back(vertex_req($urandom_range(2000) - 1000,
                    $urandom_range(2000) - 1000, $urandom_range(12000) - 100));
            if ($urandom_range(19) == 0)
                pending_reqs.push_back(coef_req($urandom_range(15), rand_word()));
        end
    endtask

    initial
    begin
        int ph;
        coef_mem = '{default: '0};
        m_mode = MODE_STANDARD;
        m_lens = 16'd256;
        m_center = '0;
        m_window = '0;
        m_fade_lim = '0;
        m_splits = '0;
        m_zoom = 31'd65536;
        m_doff = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset defaults, then extremes
        pending_reqs.push_back(vertex_req(32'h7fff_ffff, 32'h8000_0000, 32'd0));
        pending_reqs.push_back(coef_req(15, 32'hffff_ffff));
        queue_matrix(1'b0);
        pending_reqs.push_back(vertex_req(32'd0, 32'd0, 32'd31));
        pending_reqs.push_back(vertex_req(32'd100, -32'sd100, 32'd32));
        pending_reqs.push_back(vertex_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_reqs.push_back(vertex_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        drain_pipeline();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            cfg_write(CFG_MODE, ph == 7 ? 32'd3 : ph % 3);
            cfg_write(CFG_LENS, ph == 0 ? 32'hffff : (ph == 1 ? 0 : $urandom_range(2000)));
            cfg_write(CFG_CENTER, ph == 0 ? 32'hffff_ffff : $urandom);
            cfg_write(CFG_WINDOW, ph == 1 ? 32'hffff_ffff : $urandom);
            cfg_write(CFG_FADE_LIMIT, ph == 2 ? 32'h7fff_ffff : $urandom_range(12000));
            cfg_write(CFG_SPLITS, ph == 3 ? 32'hffff_ffff : $urandom);
            cfg_write(CFG_ZOOM, ph == 3 ? 32'h7fff_ffff : $urandom_range(200000));
            cfg_write(CFG_DEPTH_OFFSET, ph == 0 ? 32'h8000_0000 :
                      (ph == 3 ? 32'h7fff_ffff : $urandom_range(80) - 40));
            queue_matrix(ph == 5);
            queue_vertices(60);
            drain_pipeline();
        end
        if (mismatches == 0)
            $display("vertex_transform_project_clip_core: match");
        else
            $display("vertex_transform_project_clip_core: mismatch");
        $finish;
    end
endmodule
